/* hdl/pdsc_pkg.sv */
// ----------------------------------------------------------------------------
// pdsc_pkg: shared types, widths and microcode for the dead-band step controller
// Holds the fixed-point geometry, register indexes, the datapath operation and
// jump-condition codes, and the read-only control program of the sequencer.
// ----------------------------------------------------------------------------
package pdsc_pkg;

	// fixed-point geometry
	localparam int VALUE_WIDTH   = 16;
	localparam int FRACTION_BITS = 8;

	// derived widths
	localparam int UW      = VALUE_WIDTH - 1;                  // unsigned config regs
	localparam int MAG_W   = VALUE_WIDTH + 1;                  // |target - measured|
	localparam int PROD_W  = UW + MAG_W;                       // product / dividend
	localparam int QUO_W   = (UW >= FRACTION_BITS) ? (UW - FRACTION_BITS + 1) : 1;
	localparam int DSH_W   = UW + FRACTION_BITS + QUO_W - 1;   // aligned divisor
	localparam int DIV_W   = (PROD_W > DSH_W) ? PROD_W : DSH_W;
	localparam int CNT_W   = (QUO_W > 1) ? $clog2(QUO_W) : 1;
	localparam int COUNT_W = 9;
	localparam int SPEED_W = 18;
	localparam int HALF    = (2 ** FRACTION_BITS) / 2;         // half of one lsb of a step

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOWED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_E  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_E  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_R  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_R  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 3'd6;

	// register reset values (1.0, 5.0, 10.0, 10.0, 20.0)
	localparam logic [UW-1:0] ALLOWED_RST = UW'(1 << FRACTION_BITS);
	localparam logic [UW-1:0] SLOW_E_RST  = UW'(5 << FRACTION_BITS);
	localparam logic [UW-1:0] FAST_E_RST  = UW'(10 << FRACTION_BITS);
	localparam logic [UW-1:0] SLOW_R_RST  = UW'(10 << FRACTION_BITS);
	localparam logic [UW-1:0] FAST_R_RST  = UW'(20 << FRACTION_BITS);

	// datapath operations, one per control word
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_LEAVE_STANDBY,
		OP_MUL_PROP,
		OP_MUL_SLOW,
		OP_MUL_FAST,
		OP_ADD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_ROUND,
		OP_FAST_LOAD,
		OP_EMIT_MOVE,
		OP_EMIT_BAD,
		OP_EMIT_IDLE,
		OP_EMIT_RET
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_CURVE_BAD,
		C_DEADBAND,
		C_RETURN,
		C_FAST,
		C_PROP,
		C_DIV_MORE
	} cond_t;

	typedef logic [4:0] upc_t;

	// program addresses
	localparam upc_t UPC_FETCH     = 5'd0;
	localparam upc_t UPC_CHECK     = 5'd1;
	localparam upc_t UPC_DEADBAND  = 5'd2;
	localparam upc_t UPC_LEAVE     = 5'd3;
	localparam upc_t UPC_FAST_TEST = 5'd4;
	localparam upc_t UPC_PROP      = 5'd5;
	localparam upc_t UPC_MUL_SLOW  = 5'd6;
	localparam upc_t UPC_MUL_FAST  = 5'd7;
	localparam upc_t UPC_ADD       = 5'd8;
	localparam upc_t UPC_DIV_INIT  = 5'd9;
	localparam upc_t UPC_DIV_STEP  = 5'd10;
	localparam upc_t UPC_ROUND     = 5'd11;
	localparam upc_t UPC_EMIT_MOVE = 5'd12;
	localparam upc_t UPC_FAST_LOAD = 5'd13;
	localparam upc_t UPC_EMIT_BAD  = 5'd14;
	localparam upc_t UPC_EMIT_IDLE = 5'd15;
	localparam upc_t UPC_EMIT_RET  = 5'd16;
	localparam upc_t UPC_LAST      = UPC_EMIT_RET;

	// one control word
	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  wait_in;
		logic  wait_out;
		upc_t  target;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		op_t  op;
		logic fire;
	} ctl_t;

	// datapath to sequencer
	typedef struct packed {
		logic curve_bad;
		logic deadband;
		logic back_to_standby;
		logic fast_region;
		logic prop_region;
		logic div_more;
		logic out_blocked;
	} status_t;

	function automatic ucode_t uw(input op_t op, input cond_t cond, input logic wait_in,
			input logic wait_out, input upc_t target);
		ucode_t w;
		w.op       = op;
		w.cond     = cond;
		w.wait_in  = wait_in;
		w.wait_out = wait_out;
		w.target   = target;
		return w;
	endfunction

	// control program
	function automatic ucode_t ucode_word(input upc_t addr);
		ucode_t w;
		unique case (addr)
			UPC_FETCH:     w = uw(OP_LOAD,          C_NEVER,     1'b1, 1'b0, UPC_FETCH);
			UPC_CHECK:     w = uw(OP_NOP,           C_CURVE_BAD, 1'b0, 1'b0, UPC_EMIT_BAD);
			UPC_DEADBAND:  w = uw(OP_NOP,           C_DEADBAND,  1'b0, 1'b0, UPC_EMIT_IDLE);
			UPC_LEAVE:     w = uw(OP_LEAVE_STANDBY, C_RETURN,    1'b0, 1'b0, UPC_EMIT_RET);
			UPC_FAST_TEST: w = uw(OP_NOP,           C_FAST,      1'b0, 1'b0, UPC_FAST_LOAD);
			UPC_PROP:      w = uw(OP_MUL_PROP,      C_PROP,      1'b0, 1'b0, UPC_DIV_INIT);
			UPC_MUL_SLOW:  w = uw(OP_MUL_SLOW,      C_NEVER,     1'b0, 1'b0, UPC_FETCH);
			UPC_MUL_FAST:  w = uw(OP_MUL_FAST,      C_NEVER,     1'b0, 1'b0, UPC_FETCH);
			UPC_ADD:       w = uw(OP_ADD,           C_NEVER,     1'b0, 1'b0, UPC_FETCH);
			UPC_DIV_INIT:  w = uw(OP_DIV_INIT,      C_NEVER,     1'b0, 1'b0, UPC_FETCH);
			UPC_DIV_STEP:  w = uw(OP_DIV_STEP,      C_DIV_MORE,  1'b0, 1'b0, UPC_DIV_STEP);
			UPC_ROUND:     w = uw(OP_ROUND,         C_NEVER,     1'b0, 1'b0, UPC_FETCH);
			UPC_EMIT_MOVE: w = uw(OP_EMIT_MOVE,     C_ALWAYS,    1'b0, 1'b1, UPC_FETCH);
			UPC_FAST_LOAD: w = uw(OP_FAST_LOAD,     C_ALWAYS,    1'b0, 1'b0, UPC_EMIT_MOVE);
			UPC_EMIT_BAD:  w = uw(OP_EMIT_BAD,      C_ALWAYS,    1'b0, 1'b1, UPC_FETCH);
			UPC_EMIT_IDLE: w = uw(OP_EMIT_IDLE,     C_ALWAYS,    1'b0, 1'b1, UPC_FETCH);
			UPC_EMIT_RET:  w = uw(OP_EMIT_RET,      C_ALWAYS,    1'b0, 1'b1, UPC_FETCH);
			default:       w = uw(OP_NOP,           C_ALWAYS,    1'b0, 1'b0, UPC_FETCH);
		endcase
		return w;
	endfunction

endpackage

/* hdl/pdsc_sequencer.sv */
// ----------------------------------------------------------------------------
// pdsc_sequencer: microprogram counter and control store
// Fetches one control word per step, holds on input or output waits and
// takes conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module pdsc_sequencer
	import pdsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t st,
	output ctl_t    ctl
);

	upc_t   upc_q;
	ucode_t cw;
	logic   jump;
	logic   hold;

	// control store read
	assign cw = ucode_word(upc_q);

	// jump condition select
	always_comb begin
		unique case (cw.cond)
			C_NEVER:     jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_CURVE_BAD: jump = st.curve_bad;
			C_DEADBAND:  jump = st.deadband;
			C_RETURN:    jump = st.back_to_standby;
			C_FAST:      jump = st.fast_region;
			C_PROP:      jump = st.prop_region;
			C_DIV_MORE:  jump = st.div_more;
			default:     jump = 1'b0;
		endcase
	end

	// a step waits for an input beat or for room in the output register
	assign hold = (cw.wait_in && !in_valid) || (cw.wait_out && st.out_blocked);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_FETCH;
		end else if (!hold) begin
			upc_q <= jump ? cw.target : upc_q + 1'b1;
		end
	end

	assign in_stall = !cw.wait_in;
	assign ctl.op   = cw.op;
	assign ctl.fire = !hold;

	// program counter stays inside the program
	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= UPC_LAST)
		else $error("microprogram counter left the program");

endmodule

/* hdl/pdsc_datapath.sv */
// ----------------------------------------------------------------------------
// pdsc_datapath: registers, shared multiplier and restoring divider
// Executes one operation per control word: error magnitude, curve products,
// one quotient bit per divide step, half-up rounding and the result beat.
// ----------------------------------------------------------------------------
module pdsc_datapath
	import pdsc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [VALUE_WIDTH-1:0]      cfg_data,
	input  logic signed [VALUE_WIDTH-1:0] measured_value,
	input  ctl_t                        ctl,
	output status_t                     st,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [COUNT_W-1:0]   step_count,
	output logic [SPEED_W-1:0]          step_speed,
	output logic                        in_standby,
	output logic                        curve_bad
);

	localparam int CX  = QUO_W + COUNT_W;
	localparam int SPX = SPEED_W + UW + FRACTION_BITS + 3;

	// configuration
	logic [VALUE_WIDTH-1:0] target_q;
	logic [UW-1:0]          allowed_q;
	logic [UW-1:0]          slow_err_q;
	logic [UW-1:0]          fast_err_q;
	logic [UW-1:0]          slow_rate_q;
	logic [UW-1:0]          fast_rate_q;
	logic                   invert_q;
	logic                   mode_q;

	// working registers
	logic [MAG_W-1:0]   mag_q;
	logic               neg_q;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  acc_q;
	logic [UW-1:0]      den_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   dsh_q;
	logic [QUO_W-1:0]   quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [QUO_W-1:0]   move_q;
	logic [SPEED_W-1:0] spd_q;
	logic               interp_q;

	// result register
	logic                      out_valid_q;
	logic signed [COUNT_W-1:0] count_q;
	logic [SPEED_W-1:0]        speed_q;
	logic                      standby_q;
	logic                      bad_q;

	logic [MAG_W-1:0]  err;
	logic [MAG_W-1:0]  err_mag;
	logic [MAG_W+2:0]  mag5;
	logic [UW-1:0]     mul_a;
	logic [MAG_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_p;
	logic              div_ge;
	logic [DIV_W:0]    den_fix;
	logic [DIV_W:0]    rem_x;
	logic              round_up;
	logic [QUO_W-1:0]  move_rnd;
	logic [QUO_W-1:0]  move_fast;
	logic [CX-1:0]     mv_x;
	logic [CX-1:0]     cnt_x;
	logic              emit;

	// signed error and its magnitude
	assign err     = {target_q[VALUE_WIDTH-1], target_q}
		- {measured_value[VALUE_WIDTH-1], measured_value};
	assign err_mag = err[MAG_W-1] ? (~err + 1'b1) : err;

	// status for jumps
	assign mag5 = {mag_q, 2'b00} + (MAG_W+3)'(mag_q);
	assign st.curve_bad       = !((slow_err_q > allowed_q) && (fast_err_q > slow_err_q));
	assign st.deadband        = mode_q && (mag_q <= MAG_W'(allowed_q));
	assign st.back_to_standby = mag5 <= (MAG_W+3)'(allowed_q);
	assign st.fast_region     = mag_q >= MAG_W'(fast_err_q);
	assign st.prop_region     = mag_q <= MAG_W'(slow_err_q);
	assign st.div_more        = cnt_q != '0;
	assign st.out_blocked     = out_valid_q && out_stall;

	// shared multiplier operands
	always_comb begin
		unique case (ctl.op)
			OP_MUL_SLOW: begin
				mul_a = slow_rate_q;
				mul_b = MAG_W'(fast_err_q) - mag_q;
			end
			OP_MUL_FAST: begin
				mul_a = fast_rate_q;
				mul_b = mag_q - MAG_W'(slow_err_q);
			end
			default: begin
				mul_a = slow_rate_q;
				mul_b = mag_q;
			end
		endcase
	end
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// divide step compare and final rounding
	assign div_ge    = rem_q >= dsh_q;
	assign den_fix   = (DIV_W+1)'(den_q) << FRACTION_BITS;
	assign rem_x     = {rem_q, 1'b0};
	assign round_up  = rem_x >= den_fix;
	assign move_rnd  = quo_q + QUO_W'(round_up);
	assign move_fast = QUO_W'(((UW+1)'(fast_rate_q) + (UW+1)'(HALF)) >> FRACTION_BITS);

	// signed whole-step count
	assign mv_x  = CX'(move_q);
	assign cnt_x = (neg_q ^ invert_q) ? (~mv_x + CX'(1)) : mv_x;

	assign emit = ctl.fire && (ctl.op inside {OP_EMIT_MOVE, OP_EMIT_BAD, OP_EMIT_IDLE,
		OP_EMIT_RET});

	// configuration, mode and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			allowed_q   <= ALLOWED_RST;
			slow_err_q  <= SLOW_E_RST;
			fast_err_q  <= FAST_E_RST;
			slow_rate_q <= SLOW_R_RST;
			fast_rate_q <= FAST_R_RST;
			invert_q    <= 1'b0;
			mode_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.fire && ctl.op == OP_LEAVE_STANDBY) begin
				mode_q <= 1'b0;
			end else if (ctl.fire && ctl.op == OP_EMIT_RET) begin
				mode_q <= 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TARGET: begin
						target_q <= cfg_data;
						mode_q   <= 1'b0;
					end
					REG_ALLOWED: allowed_q   <= cfg_data[UW-1:0];
					REG_SLOW_E:  slow_err_q  <= cfg_data[UW-1:0];
					REG_FAST_E:  fast_err_q  <= cfg_data[UW-1:0];
					REG_SLOW_R:  slow_rate_q <= cfg_data[UW-1:0];
					REG_FAST_R:  fast_rate_q <= cfg_data[UW-1:0];
					REG_INVERT:  invert_q    <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// operation execution
	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			unique case (ctl.op) inside
				OP_LOAD: begin
					mag_q <= err_mag;
					neg_q <= err[MAG_W-1];
				end
				OP_MUL_PROP: begin
					acc_q    <= mul_p;
					den_q    <= slow_err_q;
					spd_q    <= SPEED_W'(SPX'(slow_rate_q) << 2);
					interp_q <= 1'b0;
				end
				OP_MUL_SLOW: begin
					prod_q   <= mul_p;
					den_q    <= fast_err_q - slow_err_q;
					interp_q <= 1'b1;
				end
				OP_MUL_FAST: begin
					acc_q  <= prod_q;
					prod_q <= mul_p;
				end
				OP_ADD: acc_q <= acc_q + prod_q;
				OP_DIV_INIT: begin
					rem_q <= DIV_W'(acc_q);
					dsh_q <= DIV_W'(den_q) << (FRACTION_BITS + QUO_W - 1);
					quo_q <= '0;
					cnt_q <= CNT_W'(QUO_W - 1);
				end
				OP_DIV_STEP: begin
					if (div_ge) begin
						rem_q <= rem_q - dsh_q;
					end
					quo_q <= (quo_q << 1) | QUO_W'(div_ge);
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - 1'b1;
				end
				OP_ROUND: begin
					move_q <= move_rnd;
					if (interp_q) begin
						spd_q <= SPEED_W'(SPX'(move_rnd) << (FRACTION_BITS + 2));
					end
				end
				OP_FAST_LOAD: begin
					move_q <= move_fast;
					spd_q  <= SPEED_W'(SPX'(fast_rate_q) << 2);
				end
				OP_EMIT_MOVE: begin
					count_q   <= cnt_x[COUNT_W-1:0];
					speed_q   <= spd_q;
					standby_q <= 1'b0;
					bad_q     <= 1'b0;
				end
				OP_EMIT_BAD: begin
					count_q   <= '0;
					speed_q   <= '0;
					standby_q <= mode_q;
					bad_q     <= 1'b1;
				end
				OP_EMIT_IDLE, OP_EMIT_RET: begin
					count_q   <= '0;
					speed_q   <= '0;
					standby_q <= 1'b1;
					bad_q     <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign step_count = count_q;
	assign step_speed = speed_q;
	assign in_standby = standby_q;
	assign curve_bad  = bad_q;

	// suppressed beats carry no motion
	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && curve_bad |-> step_count == '0 && step_speed == '0)
		else $error("bad-curve beat carries motion");

	a_standby_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_standby |-> step_count == '0 && step_speed == '0)
		else $error("standby beat carries motion");

	// divider leaves a remainder below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire && ctl.op == OP_ROUND |-> {1'b0, rem_q} < den_fix)
		else $error("divider remainder not below divisor");

endmodule

/* hdl/piecewise_deadband_step_controller_core.sv */
// ----------------------------------------------------------------------------
// piecewise_deadband_step_controller_core: dead-band step controller top level
// Joins the microcoded sequencer and its datapath behind valid/stall beats.
// ----------------------------------------------------------------------------
// One measured value in, one result beat out. Items are handled one at a time
// by a short microprogram that runs one step per cycle while no step is held
// on an input or output wait. A bad curve, the dead band and a return to
// standby branch straight to their result beat, the fast region loads its
// move directly, and the proportional region and the span between the knees
// go through the restoring divider, which produces one quotient bit per
// cycle (8 bits at Q8.8). A held result beat does not block the next input
// beat, but the following result waits for the output register to drain.
// Configuration writes take effect at once and must be made while no item is in
// flight; a write of the target forces adjust mode.
module piecewise_deadband_step_controller_core
	import pdsc_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [VALUE_WIDTH-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] measured_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COUNT_W-1:0]     step_count,
	output logic [SPEED_W-1:0]            step_speed,
	output logic                          in_standby,
	output logic                          curve_bad
);

	ctl_t    ctl;
	status_t st;

	// control program
	pdsc_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.ctl      (ctl)
	);

	// arithmetic and result register
	pdsc_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.measured_value (measured_value),
		.ctl            (ctl),
		.st             (st),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.step_count     (step_count),
		.step_speed     (step_speed),
		.in_standby     (in_standby),
		.curve_bad      (curve_bad)
	);

endmodule

/* tb/tb_piecewise_deadband_step_controller_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_deadband_step_controller_core: self-checking bench for the core
// Streams measured values through the valid/stall input channel and predicts
// every result beat. The prediction keeps its own copy of the curve registers
// and of the standby/adjust mode. Directed ticks cover the knees, the dead-band
// edges, the sign handling and bad curves. Random phases then reprogram the
// curve between drained batches, with random idling on both channels but in the last third.
// ----------------------------------------------------------------------------
module tb_piecewise_deadband_step_controller_core;
	import pdsc_pkg::*;

	localparam int RANDOM_PHASES    = 12;
	localparam int RANDOM_PER_PHASE = 136;
	localparam int SETTLE_CYCLES    = 30;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// one predicted result beat
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [SPEED_W-1:0] speed;
		logic               standby;
		logic               bad;
	} move_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [VALUE_WIDTH-1:0]        cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic signed [VALUE_WIDTH-1:0] measured_value = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [COUNT_W-1:0]     step_count;
	logic [SPEED_W-1:0]            step_speed;
	logic                          in_standby;
	logic                          curve_bad;

	// shadow copy of the curve registers and the hysteresis mode
	logic signed [VALUE_WIDTH-1:0] target_m = '0;
	logic [UW-1:0] allowed_m = ALLOWED_RST;
	logic [UW-1:0] slow_e_m  = SLOW_E_RST;
	logic [UW-1:0] fast_e_m  = FAST_E_RST;
	logic [UW-1:0] slow_r_m  = SLOW_R_RST;
	logic [UW-1:0] fast_r_m  = FAST_R_RST;
	logic          invert_m  = 1'b0;
	logic          standby_m = 1'b1;

	logic [VALUE_WIDTH-1:0] measured_feed[$];
	move_t                  expected_moves[$];
	int                     mismatch_count = 0;
	int                     send_idle_pct = 37;
	int                     recv_idle_pct = 57;
	int                     quiet_cycles = 0;

	piecewise_deadband_step_controller_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.measured_value (measured_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.step_count     (step_count),
		.step_speed     (step_speed),
		.in_standby     (in_standby),
		.curve_bad      (curve_bad)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// n/d rounded half up, n >= 0, d > 0
	function automatic longint round_half_up(input longint n, input longint d);
		longint q;
		q = n / d;
		if (n % d >= d - n % d) q++;
		return q;
	endfunction

	// result of one tick; advances the shadow mode
	function automatic move_t predict_step_move(input logic signed [VALUE_WIDTH-1:0] meas);
		longint err, mag, al, se, fe, sr, fr, span, num, mv, spd;
		bit     neg;
		move_t  r;
		al  = allowed_m;
		se  = slow_e_m;
		fe  = fast_e_m;
		sr  = slow_r_m;
		fr  = fast_r_m;
		err = longint'(target_m) - longint'(meas);
		neg = err < 0;
		mag = neg ? -err : err;
		r   = '0;
		// knees out of order: output suppressed, mode kept
		if (!(se > al && fe > se)) begin
			r.standby = standby_m;
			r.bad = 1'b1;
			return r;
		end
		if (standby_m) begin
			if (mag <= al) begin
				r.standby = 1'b1;
				return r;
			end
			standby_m = 1'b0;
		end
		// back to standby inside a fifth of the dead band
		if (mag * 5 <= al) begin
			standby_m = 1'b1;
			r.standby = 1'b1;
			return r;
		end
		if (mag <= se) begin
			mv  = round_half_up(sr * mag, se << FRACTION_BITS);
			spd = sr * 4;
		end else if (mag >= fe) begin
			mv  = round_half_up(fr, longint'(1) << FRACTION_BITS);
			spd = fr * 4;
		end else begin
			span = fe - se;
			num  = sr * span + (fr - sr) * (mag - se);
			if (num < 0) num = 0;
			mv  = round_half_up(num, span << FRACTION_BITS);
			spd = (mv * 4) << FRACTION_BITS;
		end
		if (invert_m) neg = !neg;
		r.count = neg ? COUNT_W'(-mv) : COUNT_W'(mv);
		r.speed = SPEED_W'(spd);
		return r;
	endfunction

	function automatic longint near(input longint x);
		longint v;
		v = x + $urandom_range(0, 2) - 1;
		return (v < 0) ? 0 : v;
	endfunction

	// measured value aimed at one region of the current curve
	function automatic logic [VALUE_WIDTH-1:0] pick_measured();
		int unsigned a, s, f, cat;
		longint      m, v;
		a   = allowed_m;
		s   = slow_e_m;
		f   = fast_e_m;
		cat = $urandom_range(0, 99);
		if (cat < 8) return VALUE_WIDTH'($urandom);
		if (cat < 20) m = $urandom_range(0, a / 5 + 1);
		else if (cat < 35) m = $urandom_range(a / 5, a);
		else if (cat < 40) m = near(a);
		else if (cat < 60) m = $urandom_range(a + 1, s);
		else if (cat < 65) m = near(s);
		else if (cat < 82) m = $urandom_range(s + 1, f);
		else if (cat < 87) m = near(f);
		else m = $urandom_range(f, 65535);
		v = $urandom_range(0, 1) ? longint'(target_m) - m : longint'(target_m) + m;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return VALUE_WIDTH'(v);
	endfunction

	// unsigned register value with a random unused top bit
	function automatic logic [VALUE_WIDTH-1:0] with_junk(input int unsigned v);
		return {1'($urandom), UW'(v)};
	endfunction

	// one register write, mirrored into the shadow copy
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_WIDTH-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_TARGET: begin
				target_m  = data;
				standby_m = 1'b0;
			end
			REG_ALLOWED: allowed_m = data[UW-1:0];
			REG_SLOW_E:  slow_e_m = data[UW-1:0];
			REG_FAST_E:  fast_e_m = data[UW-1:0];
			REG_SLOW_R:  slow_r_m = data[UW-1:0];
			REG_FAST_R:  fast_r_m = data[UW-1:0];
			REG_INVERT:  invert_m = data[0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// wait for every pending tick and result, then let the core settle
	task automatic drain();
		do @(negedge clk);
		while (measured_feed.size() != 0 || in_valid || expected_moves.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure_phase(input int p);
		int unsigned al, se, fe, sr, fr;
		sr = $urandom_range(0, 32767);
		fr = $urandom_range(0, 32767);
		case (p % 6)
			0: begin
				al = $urandom_range(0, 1500);
				se = al + $urandom_range(1, 3000);
				fe = se + $urandom_range(1, 6000);
			end
			1: begin
				al = 0;
				se = 1;
				fe = 2;
				sr = $urandom_range(0, 1) ? 32767 : 0;
				fr = $urandom_range(0, 1) ? 32767 : 0;
			end
			2: begin
				al = 32765;
				se = 32766;
				fe = 32767;
				sr = $urandom_range(0, 1) ? 32767 : 0;
				fr = $urandom_range(0, 1) ? 32767 : 0;
			end
			3: begin
				// knees out of order
				al = $urandom_range(0, 32767);
				se = $urandom_range(0, al);
				fe = $urandom_range(0, 32767);
			end
			4: begin
				al = $urandom_range(0, 10000);
				se = al + $urandom_range(1, 10000);
				fe = se + $urandom_range(1, 32767 - se);
			end
			default: begin
				al = ALLOWED_RST;
				se = SLOW_E_RST;
				fe = FAST_E_RST;
			end
		endcase
		if (p % 2 == 0) begin
			case ($urandom_range(0, 3))
				0: write_reg(REG_TARGET, 16'h8000);
				1: write_reg(REG_TARGET, 16'h7fff);
				default: write_reg(REG_TARGET, VALUE_WIDTH'($urandom));
			endcase
		end
		write_reg(REG_ALLOWED, with_junk(al));
		write_reg(REG_SLOW_E, with_junk(se));
		write_reg(REG_FAST_E, with_junk(fe));
		write_reg(REG_SLOW_R, with_junk(sr));
		write_reg(REG_FAST_R, with_junk(fr));
		write_reg(REG_INVERT, {VALUE_WIDTH'($urandom)} | VALUE_WIDTH'(1'($urandom)));
		end_writes();
	endtask

	// input driver: predicts each accepted beat, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) expected_moves.push_back(predict_step_move(measured_value));
			if (!in_valid || !in_stall) begin
				if (measured_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid       <= 1'b1;
					measured_value <= measured_feed.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compares each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		move_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_moves.size() == 0) begin
					$error("result beat with no tick pending");
					mismatch_count++;
				end else begin
					want = expected_moves.pop_front();
					if (step_count !== want.count) begin
						$error("step_count expected %0d actual %0d", $signed(want.count), step_count);
						mismatch_count++;
					end
					if (step_speed !== want.speed) begin
						$error("step_speed expected %0d actual %0d", want.speed, step_speed);
						mismatch_count++;
					end
					if (in_standby !== want.standby) begin
						$error("in_standby expected %0d actual %0d", want.standby, in_standby);
						mismatch_count++;
					end
					if (curve_bad !== want.bad) begin
						$error("curve_bad expected %0d actual %0d", want.bad, curve_bad);
						mismatch_count++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("piecewise_deadband_step_controller_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default curve: dead band, both knees, wide errors, return to standby
		measured_feed.push_back(16'sd0);
		measured_feed.push_back(-16'sd256);
		measured_feed.push_back(16'sd256);
		measured_feed.push_back(-16'sd257);
		measured_feed.push_back(-16'sd1280);
		measured_feed.push_back(-16'sd1281);
		measured_feed.push_back(16'sd1281);
		measured_feed.push_back(-16'sd2559);
		measured_feed.push_back(-16'sd2560);
		measured_feed.push_back(16'sh7fff);
		measured_feed.push_back(16'sh8000);
		measured_feed.push_back(-16'sd51);
		measured_feed.push_back(-16'sd52);
		drain();

		// unused index, inverted sign, target at the top of its range
		write_reg(REG_UNUSED, 16'h0000);
		write_reg(REG_INVERT, 16'h0001);
		write_reg(REG_TARGET, 16'h7fff);
		end_writes();
		measured_feed.push_back(16'sh7fff);
		measured_feed.push_back(16'sh8000);
		measured_feed.push_back(16'sh7fff - 16'sd300);
		drain();

		// slow knee equal to the dead band, then both knees equal
		write_reg(REG_SLOW_E, 16'd256);
		end_writes();
		measured_feed.push_back(16'sh8000);
		measured_feed.push_back(16'sd0);
		drain();
		write_reg(REG_SLOW_E, 16'd1280);
		write_reg(REG_FAST_E, 16'd1280);
		end_writes();
		measured_feed.push_back(16'sh7fff);
		measured_feed.push_back(16'sd0);
		drain();

		// random curves; idling schedule changes every third of the run
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < RANDOM_PHASES / 3) begin
				send_idle_pct = 37;
				recv_idle_pct = 57;
			end else if (p < 2 * RANDOM_PHASES / 3) begin
				send_idle_pct = 57;
				recv_idle_pct = 37;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			configure_phase(p);
			repeat (RANDOM_PER_PHASE) measured_feed.push_back(pick_measured());
			drain();
		end

		if (expected_moves.size() != 0) mismatch_count++;
		if (mismatch_count == 0) begin
			$display("piecewise_deadband_step_controller_core verification clean");
		end else begin
			$display("piecewise_deadband_step_controller_core verification failed");
		end
		$finish;
	end

endmodule
